### rtl/alp_pkg.sv
package alp_pkg;

    localparam int KW_LEN   = 18;
    localparam int KW_POS_W = 5;
    localparam logic [8*KW_LEN-1:0] KW_TEXT = {"FILE_", "NAMES_", "ALIASES"};

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_ALIAS = 2'd1;
    localparam logic [1:0] KIND_NAME  = 2'd2;
    localparam logic [1:0] KIND_EOL   = 2'd3;

    localparam logic [2:0] LT_BLANK     = 3'd0;
    localparam logic [2:0] LT_COMMENT   = 3'd1;
    localparam logic [2:0] LT_KEYWORD   = 3'd2;
    localparam logic [2:0] LT_ALIAS     = 3'd3;
    localparam logic [2:0] LT_MALFORMED = 3'd4;

    // Classified byte handed from front to back.
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       blank;
        logic       quote;
        logic       bslash;
        logic       bang;
    } t_cls;

    function automatic logic [7:0] kw_char(input logic [KW_POS_W-1:0] pos);
        logic [7:0] res;
        res = 8'h00;
        for (int k = 0; k < KW_LEN; k++) begin
            if (pos == KW_POS_W'(k)) begin
                res = KW_TEXT[8*(KW_LEN-1-k) +: 8];
            end
        end
        return res;
    endfunction

endpackage

### rtl/alp_in_if.sv
interface alp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

### rtl/alp_out_if.sv
interface alp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic [2:0] line_type;

    modport source (output valid, output out_kind, output out_char, output line_type,
                    input ready);
    modport sink   (input valid, input out_kind, input out_char, input line_type,
                    output ready);
endinterface

### rtl/alp_front.sv
module alp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    alp_in_if.sink        i_in,
    output logic          o_valid,
    output alp_pkg::t_cls o_item,
    input  logic          i_pop
);
    import alp_pkg::*;

    t_cls       w_cls;
    t_cls       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       w_push;
    logic       w_pop;

    // Classify the byte.
    always_comb begin
        w_cls.ch     = i_in.char_in;
        w_cls.eol    = (i_in.char_in == CH_NUL) || (i_in.char_in == CH_LF);
        w_cls.blank  = (i_in.char_in == CH_SPACE) || (i_in.char_in == CH_TAB);
        w_cls.quote  = (i_in.char_in == CH_QUOTE);
        w_cls.bslash = (i_in.char_in == CH_BSLASH);
        w_cls.bang   = (i_in.char_in == CH_BANG);
    end

    assign i_in.ready = (r_count != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != 2'd0);
    assign o_valid    = (r_count != 2'd0);
    assign o_item     = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cls;
        end
    end

endmodule

### rtl/alp_back.sv
module alp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  alp_pkg::t_cls i_item,
    output logic          o_pop,
    alp_out_if.source     o_out
);
    import alp_pkg::*;

    typedef enum logic [2:0] {
        PH_START, PH_COMMENT, PH_ALIAS, PH_AFTER_ALIAS, PH_SEP, PH_NAME, PH_TRAIL
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [KW_POS_W-1:0]   r_kw_pos, n_kw_pos;
    logic                  r_kw_alive, n_kw_alive;
    logic                  r_in_quotes, n_in_quotes;
    logic                  r_esc, n_esc;
    logic                  r_failed, n_failed;

    logic                  r_out_valid;
    logic [1:0]            r_out_kind, n_out_kind;
    logic [7:0]            r_out_char, n_out_char;
    logic [2:0]            r_line_type, n_line_type;

    logic                  w_field;
    logic                  w_first;
    logic                  w_emit;
    logic                  w_fld_end;
    logic [2:0]            w_end_type;

    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    // Line type as reported at the line end.
    always_comb begin
        if (r_phase == PH_START) begin
            w_end_type = LT_BLANK;
        end else if (r_phase == PH_COMMENT) begin
            w_end_type = LT_COMMENT;
        end else if (r_kw_alive && (r_kw_pos == KW_POS_W'(KW_LEN))) begin
            w_end_type = LT_KEYWORD;
        end else if (r_failed) begin
            w_end_type = LT_MALFORMED;
        end else begin
            case (r_phase)
                PH_SEP, PH_TRAIL: w_end_type = LT_ALIAS;
                PH_NAME:          w_end_type = (r_esc || r_in_quotes) ? LT_MALFORMED : LT_ALIAS;
                default:          w_end_type = LT_MALFORMED;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_kw_pos    = r_kw_pos;
        n_kw_alive  = r_kw_alive;
        n_in_quotes = r_in_quotes;
        n_esc       = r_esc;
        n_failed    = r_failed;
        n_out_kind  = KIND_NONE;
        n_out_char  = 8'h00;
        n_line_type = LT_BLANK;
        w_emit      = 1'b0;
        w_fld_end   = 1'b0;

        // Does this byte go through the field logic, and does it open a field?
        w_first = ((r_phase == PH_START) && !i_item.bang) || (r_phase == PH_SEP);
        w_field = !r_failed && (((r_phase == PH_START || r_phase == PH_SEP)
                                 && !i_item.blank && w_first)
                                || r_phase == PH_ALIAS || r_phase == PH_NAME);

        if (i_item.eol) begin
            n_out_kind  = KIND_EOL;
            n_line_type = w_end_type;
            n_phase     = PH_START;
            n_kw_pos    = '0;
            n_kw_alive  = 1'b1;
            n_in_quotes = 1'b0;
            n_esc       = 1'b0;
            n_failed    = 1'b0;
        end else begin
            // Keyword match runs on every non-leading byte of the line while the match is still alive.
            if (!((r_phase == PH_START) && i_item.blank) && r_kw_alive) begin
                if (r_kw_pos < KW_POS_W'(KW_LEN)) begin
                    if (i_item.ch == kw_char(r_kw_pos)) begin
                        n_kw_pos = r_kw_pos + 1'b1;
                    end else begin
                        n_kw_alive = 1'b0;
                    end
                end else if (!i_item.blank) begin
                    n_kw_alive = 1'b0;
                end
            end

            if (w_field) begin
                if (w_first && i_item.quote) begin
                    n_in_quotes = 1'b1;
                end else if (r_esc) begin
                    n_esc  = 1'b0;
                    w_emit = 1'b1;
                end else if (i_item.bslash) begin
                    n_esc = 1'b1;
                end else if (r_in_quotes ? i_item.quote : i_item.blank) begin
                    w_fld_end = 1'b1;
                end else begin
                    w_emit = 1'b1;
                end
            end

            if (!r_failed) begin
                case (r_phase)
                    PH_START: begin
                        if (!i_item.blank) begin
                            n_phase = i_item.bang ? PH_COMMENT : PH_ALIAS;
                        end
                    end
                    PH_ALIAS: begin
                        if (w_fld_end) begin
                            n_phase     = r_in_quotes ? PH_AFTER_ALIAS : PH_SEP;
                            n_in_quotes = 1'b0;
                        end
                    end
                    PH_AFTER_ALIAS: begin
                        if (i_item.blank) begin
                            n_phase = PH_SEP;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_SEP: begin
                        if (!i_item.blank) begin
                            n_phase = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (w_fld_end) begin
                            n_phase     = PH_TRAIL;
                            n_in_quotes = 1'b0;
                        end
                    end
                    PH_TRAIL: begin
                        if (!i_item.blank) begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_COMMENT: ;
                    default: n_failed = 1'b1;
                endcase
            end

            if (w_emit) begin
                n_out_kind = (r_phase == PH_START || r_phase == PH_ALIAS) ? KIND_ALIAS
                                                                           : KIND_NAME;
                n_out_char = i_item.ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_kw_pos    <= '0;
            r_kw_alive  <= 1'b1;
            r_in_quotes <= 1'b0;
            r_esc       <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_kw_pos    <= n_kw_pos;
                r_kw_alive  <= n_kw_alive;
                r_in_quotes <= n_in_quotes;
                r_esc       <= n_esc;
                r_failed    <= n_failed;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_kind  <= n_out_kind;
            r_out_char  <= n_out_char;
            r_line_type <= n_line_type;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_kind  = r_out_kind;
    assign o_out.out_char  = r_out_char;
    assign o_out.line_type = r_line_type;

endmodule

### rtl/alias_line_parser_top.sv
// Path: an accepted byte is written into the two-entry queue, then popped by the back
// end into the output register, where it is presented as a result item. Throughput: one
// byte per cycle while the output is not stalled; the line state update in the back end
// is a single combinational step. While a result waits, the queue takes two more bytes,
// then the input stalls. Reset: synchronous, active low; clears the queue, empties
// the output register and returns the line state to start of line, matcher armed.
module alias_line_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alp_in_if.sink    i_in,
    alp_out_if.source o_out
);
    import alp_pkg::*;

    // Front to back: classified byte and queue handshake.
    logic w_q_valid;
    t_cls w_q_item;
    logic w_q_pop;

    // Front: flag end-of-line, blank, quote, backslash and bang, then queue the item.
    alp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    // Back: advance the line state machine and keyword matcher, register the result.
    // It pops the queue whenever its output register is free or being drained.
    alp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_q_pop),
        .o_out   (o_out)
    );

endmodule

### rtl/alp_checker.sv
module alp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_char,
    input logic [2:0] i_line_type
);
    import alp_pkg::*;

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_char) && $stable(i_line_type))
        else $error("stalled result changed");

    // Line type only rides with a line end.
    a_type_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind != KIND_EOL) |-> i_line_type == LT_BLANK)
        else $error("line type outside line end");

    // Line type in range at a line end.
    a_type_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_EOL) |-> i_line_type <= LT_MALFORMED)
        else $error("line type out of range");

    // No character without a field character kind.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_kind == KIND_NONE) || (i_out_kind == KIND_EOL))
            |-> i_out_char == 8'h00)
        else $error("character on non-field result");

    // Drop the output after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind alias_line_parser_top alp_checker u_alp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.out_kind),
    .i_out_char  (o_out.out_char),
    .i_line_type (o_out.line_type)
);
